// ----- hw/rtl/bfc_pkg.sv -----
package bfc_pkg;

  // Sizes of the vertex table and the visible-face counter.
  localparam int unsigned MAX_VERTICES    = 1024;
  localparam int unsigned FACE_COUNT_BITS = 16;
  localparam int unsigned ADDR_W          = $clog2(MAX_VERTICES);

  // Field widths of the request and response channels.
  localparam int unsigned FIX_W      = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned VTX_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned FACES_W    = 16;
  localparam int unsigned PROD_W     = 2 * FIX_W;
  // Three full products plus the shifted plane distance, with a spare bit.
  localparam int unsigned ACC_W      = PROD_W + 2;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Side flag bits of a vertex entry.
  localparam logic [1:0] SIDE_NONE  = 2'b00;
  localparam logic [1:0] SIDE_FRONT = 2'b01;
  localparam logic [1:0] SIDE_BACK  = 2'b10;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CULL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CULL_NONE     = 2'd0,
    CULL_ONE_SIDE = 2'd1,
    CULL_TWO_SIDE = 2'd2
  } cull_mode_e;

  typedef enum logic [1:0] {
    PROJ_PERSPECTIVE = 2'd0,
    PROJ_PARALLEL    = 2'd1,
    PROJ_OTHER       = 2'd2
  } projection_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CULL_MODE  = 3'd0,
    REG_PROJECTION = 3'd1,
    REG_EYE_X      = 3'd2,
    REG_EYE_Y      = 3'd3,
    REG_EYE_Z      = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_RD,
    ST_WR,
    ST_READ,
    ST_DONE
  } back_state_e;

  // Configuration register file as seen by the front and the back.
  typedef struct packed {
    logic [1:0]              cull_mode;
    logic [1:0]              projection;
    logic signed [FIX_W-1:0] eye_x;
    logic signed [FIX_W-1:0] eye_y;
    logic signed [FIX_W-1:0] eye_z;
  } cfg_t;

  // One classified request waiting in the queue.
  typedef struct packed {
    cmd_e                    cmd;
    logic                    culling;
    logic                    drop_en;
    logic                    mark_en;
    logic                    persp;
    logic signed [FIX_W-1:0] plane_a;
    logic signed [FIX_W-1:0] plane_b;
    logic signed [FIX_W-1:0] plane_c;
    logic signed [FIX_W-1:0] plane_d;
    logic [2:0][ADDR_W-1:0]  vtx;
    logic [2:0]              vtx_ok;
  } job_t;

  // One entry of the vertex table.
  typedef struct packed {
    logic [1:0]         flags;
    logic [COUNT_W-1:0] count;
  } vtx_entry_t;

endpackage

// ----- hw/rtl/bfc_in_if.sv -----
interface bfc_in_if;
  import bfc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic signed [FIX_W-1:0] plane_a;
  logic signed [FIX_W-1:0] plane_b;
  logic signed [FIX_W-1:0] plane_c;
  logic signed [FIX_W-1:0] plane_d;
  logic [VTX_W-1:0]        vertex_a;
  logic [VTX_W-1:0]        vertex_b;
  logic [VTX_W-1:0]        vertex_c;

  modport source (
    output valid, cmd, plane_a, plane_b, plane_c, plane_d, vertex_a, vertex_b, vertex_c,
    input  ready
  );
  modport sink (
    input  valid, cmd, plane_a, plane_b, plane_c, plane_d, vertex_a, vertex_b, vertex_c,
    output ready
  );
endinterface

// ----- hw/rtl/bfc_out_if.sv -----
interface bfc_out_if;
  import bfc_pkg::*;

  logic               valid;
  logic               ready;
  logic               visible;
  logic               reversed;
  logic [FACES_W-1:0] visible_faces;
  logic [COUNT_W-1:0] entry_count;
  logic               entry_front;
  logic               entry_back;

  modport source (
    output valid, visible, reversed, visible_faces, entry_count, entry_front, entry_back,
    input  ready
  );
  modport sink (
    input  valid, visible, reversed, visible_faces, entry_count, entry_front, entry_back,
    output ready
  );
endinterface

// ----- hw/rtl/bfc_cfg_if.sv -----
interface bfc_cfg_if;
  import bfc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIX_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/bfc_front.sv -----
module bfc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bfc_in_if.sink        in_if,
  input  bfc_pkg::cfg_t cfg_i,
  input  logic          clearing_i,
  output bfc_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import bfc_pkg::*;

  job_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;
  logic              culling;
  job_t              job_new;

  // Culling is on only for a real cull mode under a known projection.
  assign culling = (cfg_i.cull_mode == CULL_ONE_SIDE || cfg_i.cull_mode == CULL_TWO_SIDE) &&
                   (cfg_i.projection == PROJ_PERSPECTIVE ||
                    cfg_i.projection == PROJ_PARALLEL);

  // Classify the incoming request.
  always_comb begin
    job_new.cmd       = cmd_e'(in_if.cmd);
    job_new.culling   = culling;
    job_new.drop_en   = culling && (cfg_i.cull_mode == CULL_ONE_SIDE);
    job_new.mark_en   = culling && (cfg_i.cull_mode == CULL_TWO_SIDE);
    job_new.persp     = (cfg_i.projection == PROJ_PERSPECTIVE);
    job_new.plane_a   = in_if.plane_a;
    job_new.plane_b   = in_if.plane_b;
    job_new.plane_c   = in_if.plane_c;
    job_new.plane_d   = in_if.plane_d;
    job_new.vtx[0]    = ADDR_W'(in_if.vertex_a);
    job_new.vtx[1]    = ADDR_W'(in_if.vertex_b);
    job_new.vtx[2]    = ADDR_W'(in_if.vertex_c);
    job_new.vtx_ok[0] = (32'(in_if.vertex_a) < 32'(MAX_VERTICES));
    job_new.vtx_ok[1] = (32'(in_if.vertex_b) < 32'(MAX_VERTICES));
    job_new.vtx_ok[2] = (32'(in_if.vertex_c) < 32'(MAX_VERTICES));
  end

  // Queue handshake: no request is taken while the vertex table is being cleared.
  assign in_if.ready = !clearing_i && (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign job_valid_o = (count_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = queue_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

// ----- hw/rtl/bfc_back.sv -----
module bfc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfc_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  bfc_pkg::cfg_t cfg_i,
  output logic          clearing_o,
  bfc_out_if.source     out_if
);
  import bfc_pkg::*;

  // Vertex table: use count and side flags per entry.
  vtx_entry_t mem_q [MAX_VERTICES];
  vtx_entry_t rdata_q;
  vtx_entry_t mem_wdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  back_state_e                state_q, state_d;
  logic [ADDR_W-1:0]          clr_addr_q, clr_addr_d;
  logic [FACE_COUNT_BITS-1:0] face_total_q, face_total_d;
  logic                       out_valid_q, out_valid_d;
  job_t                       job_q, job_d;
  logic [1:0]                 step_q, step_d;
  logic [1:0]                 vsel_q, vsel_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic                       vis_q, vis_d;
  logic                       rev_q, rev_d;
  logic [1:0]                 side_q, side_d;
  vtx_entry_t                 ent_q, ent_d;
  logic                       load_out;
  logic                       is_back;
  logic signed [FIX_W-1:0]    mul_a, mul_b;
  logic signed [ACC_W-1:0]    d_shift;
  logic [FACES_W-1:0]         faces_clip;

  logic                       out_vis_q, out_rev_q;
  logic [FACES_W-1:0]         out_faces_q;
  vtx_entry_t                 out_ent_q;

  // Plane distance scaled to the product format, sign-extended.
  assign d_shift = {{(ACC_W - FIX_W - FRAC_W){job_i.plane_d[FIX_W-1]}},
                    job_i.plane_d, {FRAC_W{1'b0}}};
  assign is_back = acc_q[ACC_W-1];

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    unique case (step_q)
      2'd0:    begin mul_a = job_q.plane_a; mul_b = cfg_i.eye_x; end
      2'd1:    begin mul_a = job_q.plane_b; mul_b = cfg_i.eye_y; end
      default: begin mul_a = job_q.plane_c; mul_b = cfg_i.eye_z; end
    endcase
  end

  // Reported face count saturates at the output width.
  assign faces_clip = (33'(face_total_q) > 33'({FACES_W{1'b1}})) ? {FACES_W{1'b1}}
                                                                  : FACES_W'(face_total_q);

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    face_total_d = face_total_q;
    out_valid_d  = out_valid_q;
    job_d        = job_q;
    step_d       = step_q;
    vsel_d       = vsel_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    vis_d        = vis_q;
    rev_d        = rev_q;
    side_d       = side_q;
    ent_d        = ent_q;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = job_q.vtx[vsel_q];
    mem_wdata    = '0;
    mem_raddr    = job_q.vtx[vsel_q];
    job_ready_o  = 1'b0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        if (clr_addr_q == ADDR_W'(MAX_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        job_ready_o = 1'b1;
        mem_raddr   = job_i.vtx[0];
        if (job_valid_i) begin
          job_d  = job_i;
          step_d = '0;
          vsel_d = '0;
          vis_d  = 1'b0;
          rev_d  = 1'b0;
          side_d = SIDE_NONE;
          ent_d  = '0;
          acc_d  = job_i.persp ? -d_shift : '0;
          unique case (job_i.cmd)
            CMD_START: begin
              face_total_d = '0;
              state_d      = ST_DONE;
            end
            CMD_CLEAR: begin
              mem_we    = job_i.vtx_ok[0];
              mem_waddr = job_i.vtx[0];
              state_d   = ST_DONE;
            end
            CMD_CULL: begin
              if (job_i.culling) begin
                state_d = ST_MUL;
              end else begin
                vis_d   = 1'b1;
                state_d = ST_RD;
              end
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
          endcase
        end
      end
      ST_MUL: begin
        // Multiply in one step, accumulate the registered product in the next.
        prod_d = mul_a * mul_b;
        if (step_q != 2'd0) begin
          acc_d = acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
        end
        if (step_q == 2'd3) begin
          state_d = ST_DECIDE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (job_q.drop_en && is_back) begin
          state_d = ST_DONE;
        end else begin
          vis_d   = 1'b1;
          rev_d   = job_q.mark_en && is_back;
          side_d  = !job_q.mark_en ? SIDE_NONE : (is_back ? SIDE_BACK : SIDE_FRONT);
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        // Read-modify-write of one vertex entry.
        mem_we          = job_q.vtx_ok[vsel_q];
        mem_wdata.flags = rdata_q.flags | side_q;
        mem_wdata.count = (rdata_q.count == {COUNT_W{1'b1}}) ? rdata_q.count
                                                             : rdata_q.count + 1'b1;
        if (vsel_q == 2'd2) begin
          if (face_total_q != {FACE_COUNT_BITS{1'b1}}) begin
            face_total_d = face_total_q + 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          vsel_d  = vsel_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_READ: begin
        ent_d   = job_q.vtx_ok[0] ? rdata_q : '0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      face_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      face_total_q <= face_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    step_q <= step_d;
    vsel_q <= vsel_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    vis_q  <= vis_d;
    rev_q  <= rev_d;
    side_q <= side_d;
    ent_q  <= ent_d;
    if (load_out) begin
      out_vis_q   <= vis_q;
      out_rev_q   <= rev_q;
      out_faces_q <= faces_clip;
      out_ent_q   <= ent_q;
    end
  end

  // Vertex table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign clearing_o           = (state_q == ST_CLEAR);
  assign out_if.valid         = out_valid_q;
  assign out_if.visible       = out_vis_q;
  assign out_if.reversed      = out_rev_q;
  assign out_if.visible_faces = out_faces_q;
  assign out_if.entry_count   = out_ent_q.count;
  assign out_if.entry_front   = out_ent_q.flags[0];
  assign out_if.entry_back    = out_ent_q.flags[1];

endmodule

// ----- hw/rtl/backface_cull_vertex_refcount_core.sv -----
// Channel   Modport  Moves
// in_if     sink     one request: command, face plane, three vertex indices
// out_if    source   one response per request: visibility, face count, entry
// cfg_if    sink     register write: index, data; always ready
//
// In the back sequencer, start and clear go straight to the response,
// read waits for one table read, and a cull face runs the shared 32x32
// multiplier (four steps) unless culling is off; a kept face updates
// each vertex by a read and a write state on the single write port.
// After reset all 1024 vertex table entries are swept to zero, one entry
// a cycle; no request is taken then. A two-entry queue lets the front
// take requests while the back works, and a full output register stalls it.
module backface_cull_vertex_refcount_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfc_in_if.sink    in_if,
  bfc_out_if.source out_if,
  bfc_cfg_if.sink   cfg_if
);
  import bfc_pkg::*;

  cfg_t cfg_q, cfg_d;
  job_t job;
  logic job_valid;
  logic job_ready;
  logic clearing;
  logic cfg_we;

  // Configuration register file.
  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid && cfg_if.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_if.index))
        REG_CULL_MODE:  cfg_d.cull_mode  = cfg_if.data[1:0];
        REG_PROJECTION: cfg_d.projection = cfg_if.data[1:0];
        REG_EYE_X:      cfg_d.eye_x      = cfg_if.data;
        REG_EYE_Y:      cfg_d.eye_y      = cfg_if.data;
        REG_EYE_Z:      cfg_d.eye_z      = cfg_if.data;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_i       (cfg_q),
    .clearing_i  (clearing),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  bfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .cfg_i       (cfg_q),
    .clearing_o  (clearing),
    .out_if      (out_if)
  );

  // No request enters while the vertex table sweep runs.
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !(in_if.valid && in_if.ready))
    else $error("request accepted during vertex table sweep");

  // A visible face never carries vertex entry data.
  a_visible_has_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.visible) |->
      (out_if.entry_count == '0 && !out_if.entry_front && !out_if.entry_back))
    else $error("visible face response carries entry data");

  // Only a kept face can be marked as reversed.
  a_reversed_is_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.reversed) |-> out_if.visible)
    else $error("reversed face reported as not visible");

  // The back takes a new request only after its previous response was queued.
  a_back_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid && job_ready) |=> !job_ready)
    else $error("back accepted two requests in a row");

endmodule
